// ----- rtl/dam_pkg.sv -----
// Shared types, constants and the instruction decoder of the decimal accumulator machine.
package dam_pkg;

  localparam int WORD_W        = 32;
  localparam int ADDR_W        = 7;
  localparam int MEM_WORDS_DEF = 100;
  localparam int DIV_W         = 32;
  localparam int CNT_W         = $clog2(DIV_W + 1);

  // Words at or above this value carry an opcode past the last one.
  localparam logic [WORD_W-1:0] WORD_LIMIT = 32'd1100;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_EXEC    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0,
    FLT_DIV0 = 2'd1,
    FLT_PC   = 2'd2
  } fault_t;

  typedef enum logic [3:0] {
    OP_HALT       = 4'd0,
    OP_LOAD       = 4'd1,
    OP_STORE      = 4'd2,
    OP_ADD        = 4'd3,
    OP_SUB        = 4'd4,
    OP_MUL        = 4'd5,
    OP_DIV        = 4'd6,
    OP_INPUT      = 4'd7,
    OP_OUTPUT     = 4'd8,
    OP_BRANCH     = 4'd9,
    OP_BRANCH_POS = 4'd10,
    OP_NOP        = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_OPER,
    S_EXEC,
    S_DIV,
    S_RDATA,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
  } dec_t;

  // Split a word into opcode (word / 100) and address (word % 100).
  // Only words below 1100 matter, so the quotient is a multiply by
  // 5243 / 2^19, which is exact over that range.
  function automatic dec_t decode_word(input logic [WORD_W-1:0] w);
    logic [10:0] w11;
    logic [23:0] prod;
    logic [3:0]  q;
    logic [10:0] rem;
    dec_t        d;
    w11  = w[10:0];
    prod = 24'(w11) * 24'd5243;
    q    = prod[22:19];
    rem  = w11 - 11'(11'(q) * 11'd100);
    if (w[WORD_W-1] || (w >= WORD_LIMIT)) begin
      d.op   = OP_NOP;
      d.addr = '0;
    end else begin
      d.op   = op_t'(q);
      d.addr = rem[ADDR_W-1:0];
    end
    return d;
  endfunction

endpackage

// ----- rtl/dam_if.sv -----
// Command and result channel interfaces of the decimal accumulator machine.
interface dam_in_if;
  logic                          valid;
  logic                          ready;
  dam_pkg::cmd_t                 cmd;
  logic [dam_pkg::ADDR_W-1:0]    mem_addr;
  logic signed [dam_pkg::WORD_W-1:0] mem_data;
  logic signed [dam_pkg::WORD_W-1:0] in_value;

  modport source (output valid, cmd, mem_addr, mem_data, in_value, input ready);
  modport sink   (input valid, cmd, mem_addr, mem_data, in_value, output ready);
endinterface

interface dam_out_if;
  logic                          valid;
  logic                          ready;
  logic                          io_valid;
  logic signed [dam_pkg::WORD_W-1:0] io_value;
  logic                          halted;
  dam_pkg::fault_t               fault;
  logic signed [dam_pkg::WORD_W-1:0] acc_now;
  logic [dam_pkg::ADDR_W-1:0]    pc_now;

  modport source (output valid, io_valid, io_value, halted, fault, acc_now, pc_now,
                  input ready);
  modport sink   (input valid, io_valid, io_value, halted, fault, acc_now, pc_now,
                  output ready);
endinterface

// ----- rtl/dam_mem.sv -----
// Main memory: one write port, one read port, registered read data.
module dam_mem #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input  logic                       clk,
  input  dam_pkg::mem_req_t          req,
  output logic [dam_pkg::WORD_W-1:0] rdata
);

  localparam int IDX_W = $clog2(MEM_WORDS);

  logic [dam_pkg::WORD_W-1:0] mem [MEM_WORDS];
  logic [dam_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[IDX_W-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr[IDX_W-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dam_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
module dam_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dam_pkg::DIV_W-1:0]  dividend,
  input  logic [dam_pkg::DIV_W-1:0]  divisor,
  output logic                       done,
  output logic [dam_pkg::DIV_W-1:0]  quotient
);

  localparam int W = dam_pkg::DIV_W;
  localparam logic [dam_pkg::CNT_W-1:0] CNT_INIT = dam_pkg::CNT_W'(W);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [dam_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]              rem_r, rem_nxt;
  logic [W-1:0]              quo_r, quo_nxt;
  logic [W-1:0]              dvs_r, dvs_nxt;
  logic [W:0]                rem_sh;
  logic [W:0]                trial;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    trial    = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_INIT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Keep the trial difference when it did not borrow.
      rem_nxt = trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], ~trial[W]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dam_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/decimal_accumulator_machine.sv -----
// Top level of the decimal accumulator machine: command sequencer and result register.
//
// Usage: each transaction on in_ch is one command: write a memory word, execute one
// instruction at pc, restart (pc, acc and fault cleared, machine running, memory kept)
// or read a memory word back. Every command produces exactly one transaction on
// out_ch carrying io_valid/io_value and the machine state (halted, fault, acc, pc)
// after the command.
// From accept to result register: write, restart and an execute that is refused
// (halted, or pc past memory) pass through S_FIN only, a read through S_RDATA, an
// executed instruction through S_FETCH and S_OPER, plus S_EXEC when it reads an
// operand, and a divide also waits in S_DIV. The divide is set by the divider, which
// produces one quotient bit per cycle; all other commands are set by the registered
// read of main memory, visited once for the instruction word and once for the operand.
// A new command is taken once the previous one has reached the result register,
// so one result may wait at out_ch while the next command is in flight; when the
// receiver stalls longer, the sequencer holds the finished state and stops taking
// commands until the result register frees up.
// Reset (synchronous, active low) clears acc, pc and fault and sets the machine
// running; memory contents are not cleared and must be written before use.
module decimal_accumulator_machine #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dam_in_if.sink     in_ch,
  dam_out_if.source  out_ch
);

  localparam int W = dam_pkg::WORD_W;
  localparam int A = dam_pkg::ADDR_W;
  localparam logic [A-1:0] MEM_LIMIT = A'(MEM_WORDS);

  dam_pkg::state_t   state_r, state_nxt;
  logic [W-1:0]      acc_r, acc_nxt;
  logic [A-1:0]      pc_r, pc_nxt;
  logic              running_r, running_nxt;
  dam_pkg::fault_t   fault_r, fault_nxt;
  dam_pkg::op_t      op_r, op_nxt;
  logic [A-1:0]      oa_r, oa_nxt;
  logic              a_ok_r, a_ok_nxt;
  logic [W-1:0]      inval_r, inval_nxt;
  logic              neg_r, neg_nxt;
  logic              io_vld_r, io_vld_nxt;
  logic [W-1:0]      io_val_r, io_val_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_io_vld_r;
  logic [W-1:0]      out_io_val_r;
  logic              out_halted_r;
  dam_pkg::fault_t   out_fault_r;
  logic [W-1:0]      out_acc_r;
  logic [A-1:0]      out_pc_r;

  dam_pkg::mem_req_t mem_req;
  logic [W-1:0]      mem_rdata;
  dam_pkg::dec_t     dec;
  logic [W-1:0]      opnd;
  logic              in_acc;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [W-1:0]      div_dend;
  logic [W-1:0]      div_dsor;
  logic [W-1:0]      div_quo;

  dam_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  dam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (div_dsor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ch.ready = (state_r == dam_pkg::S_IDLE);

  always_comb begin
    in_acc      = in_ch.valid && in_ch.ready;
    dec         = dam_pkg::decode_word(mem_rdata);
    // Operand addresses outside memory read as zero.
    opnd        = a_ok_r ? mem_rdata : '0;
    div_dend    = acc_r[W-1] ? (~acc_r + 1'b1) : acc_r;
    div_dsor    = opnd[W-1] ? (~opnd + 1'b1) : opnd;

    state_nxt   = state_r;
    acc_nxt     = acc_r;
    pc_nxt      = pc_r;
    running_nxt = running_r;
    fault_nxt   = fault_r;
    op_nxt      = op_r;
    oa_nxt      = oa_r;
    a_ok_nxt    = a_ok_r;
    inval_nxt   = inval_r;
    neg_nxt     = neg_r;
    io_vld_nxt  = io_vld_r;
    io_val_nxt  = io_val_r;
    mem_req     = '0;
    div_start   = 1'b0;
    out_load    = 1'b0;

    case (state_r)
      dam_pkg::S_IDLE: begin
        if (in_acc) begin
          io_vld_nxt = 1'b0;
          io_val_nxt = '0;
          inval_nxt  = in_ch.in_value;
          state_nxt  = dam_pkg::S_FIN;
          case (in_ch.cmd)
            dam_pkg::CMD_WRITE: begin
              if (in_ch.mem_addr < MEM_LIMIT) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_ch.mem_addr;
                mem_req.wdata = in_ch.mem_data;
              end
            end
            dam_pkg::CMD_EXEC: begin
              if (!running_r) begin
                // Halted: nothing changes.
              end else if (pc_r >= MEM_LIMIT) begin
                fault_nxt   = dam_pkg::FLT_PC;
                running_nxt = 1'b0;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pc_r;
                state_nxt     = dam_pkg::S_FETCH;
              end
            end
            dam_pkg::CMD_RESTART: begin
              pc_nxt      = '0;
              acc_nxt     = '0;
              running_nxt = 1'b1;
              fault_nxt   = dam_pkg::FLT_NONE;
            end
            dam_pkg::CMD_READ: begin
              io_vld_nxt = 1'b1;
              if (in_ch.mem_addr < MEM_LIMIT) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_ch.mem_addr;
                state_nxt     = dam_pkg::S_RDATA;
              end
            end
            default: ;
          endcase
        end
      end

      dam_pkg::S_FETCH: begin
        // Instruction word is on the read port; advance pc and latch the decode.
        pc_nxt    = pc_r + 1'b1;
        op_nxt    = dec.op;
        oa_nxt    = dec.addr;
        a_ok_nxt  = dec.addr < MEM_LIMIT;
        state_nxt = dam_pkg::S_OPER;
      end

      dam_pkg::S_OPER: begin
        state_nxt = dam_pkg::S_FIN;
        case (op_r)
          dam_pkg::OP_HALT: begin
            running_nxt = 1'b0;
          end
          dam_pkg::OP_STORE: begin
            mem_req.we    = a_ok_r;
            mem_req.waddr = oa_r;
            mem_req.wdata = acc_r;
          end
          dam_pkg::OP_INPUT: begin
            mem_req.we    = a_ok_r;
            mem_req.waddr = oa_r;
            mem_req.wdata = inval_r;
          end
          dam_pkg::OP_BRANCH: begin
            pc_nxt = oa_r;
          end
          dam_pkg::OP_BRANCH_POS: begin
            if (!acc_r[W-1]) begin
              pc_nxt = oa_r;
            end
          end
          dam_pkg::OP_LOAD, dam_pkg::OP_ADD, dam_pkg::OP_SUB, dam_pkg::OP_MUL,
          dam_pkg::OP_DIV, dam_pkg::OP_OUTPUT: begin
            mem_req.re    = a_ok_r;
            mem_req.raddr = oa_r;
            state_nxt     = dam_pkg::S_EXEC;
          end
          default: ;
        endcase
      end

      dam_pkg::S_EXEC: begin
        state_nxt = dam_pkg::S_FIN;
        case (op_r)
          dam_pkg::OP_LOAD:   acc_nxt = opnd;
          dam_pkg::OP_ADD:    acc_nxt = acc_r + opnd;
          dam_pkg::OP_SUB:    acc_nxt = acc_r - opnd;
          dam_pkg::OP_MUL:    acc_nxt = W'(acc_r * opnd);
          dam_pkg::OP_OUTPUT: begin
            io_vld_nxt = 1'b1;
            io_val_nxt = opnd;
          end
          dam_pkg::OP_DIV: begin
            if (opnd == '0) begin
              fault_nxt   = dam_pkg::FLT_DIV0;
              running_nxt = 1'b0;
            end else begin
              div_start = 1'b1;
              neg_nxt   = acc_r[W-1] ^ opnd[W-1];
              state_nxt = dam_pkg::S_DIV;
            end
          end
          default: ;
        endcase
      end

      dam_pkg::S_DIV: begin
        if (div_done) begin
          acc_nxt   = neg_r ? (~div_quo + 1'b1) : div_quo;
          state_nxt = dam_pkg::S_FIN;
        end
      end

      dam_pkg::S_RDATA: begin
        io_val_nxt = mem_rdata;
        state_nxt  = dam_pkg::S_FIN;
      end

      dam_pkg::S_FIN: begin
        // Hand off to the result register once it is free or draining.
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = dam_pkg::S_IDLE;
        end
      end

      default: state_nxt = dam_pkg::S_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dam_pkg::S_IDLE;
      acc_r       <= '0;
      pc_r        <= '0;
      running_r   <= 1'b1;
      fault_r     <= dam_pkg::FLT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      pc_r        <= pc_nxt;
      running_r   <= running_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    oa_r     <= oa_nxt;
    a_ok_r   <= a_ok_nxt;
    inval_r  <= inval_nxt;
    neg_r    <= neg_nxt;
    io_vld_r <= io_vld_nxt;
    io_val_r <= io_val_nxt;
    if (out_load) begin
      out_io_vld_r <= io_vld_r;
      out_io_val_r <= io_val_r;
      out_halted_r <= !running_r;
      out_fault_r  <= fault_r;
      out_acc_r    <= acc_r;
      out_pc_r     <= pc_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.io_valid = out_io_vld_r;
  assign out_ch.io_value = out_io_val_r;
  assign out_ch.halted   = out_halted_r;
  assign out_ch.fault    = out_fault_r;
  assign out_ch.acc_now  = out_acc_r;
  assign out_ch.pc_now   = out_pc_r;

`ifndef SYNTHESIS
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != dam_pkg::FLT_NONE) |-> !running_r)
    else $error("fault set while machine running");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (mem_req.waddr < MEM_LIMIT))
    else $error("memory write outside memory");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_dsor != '0))
    else $error("divider started with zero divisor");

  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dam_pkg::S_DIV && div_done) |=> (state_r == dam_pkg::S_FIN))
    else $error("divide result not taken");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_ch.valid && out_ch.pc_now == $past(pc_r)))
    else $error("result register lost the machine state");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the decimal accumulator machine: command driver, result monitor.
module testbench;
  import dam_pkg::*;

  localparam int  MEM_WORDS  = MEM_WORDS_DEF;
  localparam int  ITEM_COUNT = 1500;
  localparam int  CYCLE_CAP  = 1000000;
  localparam int  MAX_SHOWN  = 10;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;

  // One command as the driver offers it.
  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] inval;
  } command_t;

  // Machine state reported after one command.
  typedef struct packed {
    logic              io_valid;
    logic [WORD_W-1:0] io_value;
    logic              halted;
    fault_t            fault;
    logic [WORD_W-1:0] acc;
    logic [ADDR_W-1:0] pc;
  } report_t;

  logic clk;
  logic rst_n;

  dam_in_if  in_ch ();
  dam_out_if out_ch ();

  decimal_accumulator_machine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the machine, advanced once per accepted command.
  logic [WORD_W-1:0] mach_mem [MEM_WORDS];
  logic [WORD_W-1:0] mach_acc;
  logic [ADDR_W-1:0] mach_pc;
  logic              mach_run;
  fault_t            mach_fault;

  command_t command_backlog[$];
  report_t  state_reports[$];
  command_t cur_cmd;

  int cmds_total;
  int cmds_taken;
  int reports_seen;
  int err_cnt;
  int cycle_cnt;
  int send_gap;
  int stall_left;
  logic hold_off;

  // Coverage tallies kept by the shadow machine.
  int n_exec, n_read, n_write, n_restart, n_out, n_halt, n_div0, n_pcflt;

  // Most gaps short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Random memory word: mostly instructions, plus negative, unknown and data words.
  function automatic logic [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 10) * 100 + $urandom_range(0, MEM_WORDS - 1);
    if (r < 62) return {1'b1, 31'($urandom())};
    if (r < 67) return $urandom_range(32'h7fff_ffff, 1100);
    if (r < 77) begin
      case ($urandom_range(0, 4))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return '1;
        3:       return '0;
        default: return 32'd1;
      endcase
    end
    return 32'($signed($urandom_range(0, 2050)) - 50);
  endfunction

  function automatic logic [WORD_W-1:0] rand_input();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? WORD_MIN : WORD_MAX;
    return $urandom();
  endfunction

  task automatic add_cmd(input cmd_t c, input int a, input logic [WORD_W-1:0] d,
                         input logic [WORD_W-1:0] v);
    command_t item;
    item.cmd   = c;
    item.addr  = ADDR_W'(a);
    item.data  = d;
    item.inval = v;
    command_backlog.push_back(item);
  endtask

  function automatic logic [WORD_W-1:0] mem_fetch(int unsigned a);
    if (a < MEM_WORDS) return mach_mem[a];
    return '0;
  endfunction

  // Advance the shadow machine by one command and return the state it reports.
  function automatic report_t run_command(command_t c);
    report_t           r;
    logic [WORD_W-1:0] w, opnd, q, mag_a, mag_d;
    int unsigned       op, a;
    r = '0;
    case (c.cmd)
      CMD_WRITE: begin
        n_write++;
        if (c.addr < MEM_WORDS) mach_mem[c.addr] = c.data;
      end
      CMD_EXEC: begin
        n_exec++;
        if (mach_run) begin
          if (mach_pc >= MEM_WORDS) begin
            // ran off the end of memory: halt without moving pc
            mach_fault = FLT_PC;
            mach_run   = 1'b0;
            n_pcflt++;
          end else begin
            w = mach_mem[mach_pc];
            mach_pc = mach_pc + 1'b1;
            if (!w[WORD_W-1]) begin
              op   = w / 100;
              a    = w % 100;
              opnd = mem_fetch(a);
              case (op)
                OP_HALT: begin
                  mach_run = 1'b0;
                  n_halt++;
                end
                OP_LOAD:  mach_acc = opnd;
                OP_STORE: if (a < MEM_WORDS) mach_mem[a] = mach_acc;
                OP_ADD:   mach_acc = mach_acc + opnd;
                OP_SUB:   mach_acc = mach_acc - opnd;
                OP_MUL:   mach_acc = mach_acc * opnd;
                OP_DIV: begin
                  if (opnd == '0) begin
                    mach_fault = FLT_DIV0;
                    mach_run   = 1'b0;
                    n_div0++;
                  end else begin
                    // truncate toward zero on magnitudes, then fix the sign
                    mag_a = mach_acc[WORD_W-1] ? -mach_acc : mach_acc;
                    mag_d = opnd[WORD_W-1] ? -opnd : opnd;
                    q = mag_a / mag_d;
                    if (mach_acc[WORD_W-1] ^ opnd[WORD_W-1]) q = -q;
                    mach_acc = q;
                  end
                end
                OP_INPUT: if (a < MEM_WORDS) mach_mem[a] = c.inval;
                OP_OUTPUT: begin
                  r.io_valid = 1'b1;
                  r.io_value = opnd;
                  n_out++;
                end
                OP_BRANCH:     mach_pc = ADDR_W'(a);
                OP_BRANCH_POS: if (!mach_acc[WORD_W-1]) mach_pc = ADDR_W'(a);
                default: ;
              endcase
            end
          end
        end
      end
      CMD_RESTART: begin
        n_restart++;
        mach_pc    = '0;
        mach_acc   = '0;
        mach_run   = 1'b1;
        mach_fault = FLT_NONE;
      end
      default: begin
        n_read++;
        r.io_valid = 1'b1;
        r.io_value = mem_fetch(c.addr);
      end
    endcase
    r.halted = !mach_run;
    r.fault  = mach_fault;
    r.acc    = mach_acc;
    r.pc     = mach_pc;
    return r;
  endfunction

  // Clock and cycle-cap watchdog.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d of %0d commands taken", cycle_cnt, cmds_taken,
               cmds_total);
      $display("testbench failed");
      $finish;
    end
  end

  // Stretches of calm: no new gaps and no random stalls; a hold-off still stalls the receiver.
  wire calm = (cycle_cnt[11:10] == 2'b11);

  // Command driver: predict on every accepted transaction, then offer the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        state_reports.push_back(run_command(cur_cmd));
        cmds_taken <= cmds_taken + 1;
        send_gap = calm ? 0 : pick_gap();
      end
      // Slot is free when nothing is offered or the offer was just taken.
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (command_backlog.size() > 0) begin
          cur_cmd = command_backlog.pop_front();
          in_ch.cmd      <= cur_cmd.cmd;
          in_ch.mem_addr <= cur_cmd.addr;
          in_ch.mem_data <= cur_cmd.data;
          in_ch.in_value <= cur_cmd.inval;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest prediction, then pick ready.
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.io_valid = out_ch.io_valid;
        got.io_value = out_ch.io_value;
        got.halted   = out_ch.halted;
        got.fault    = out_ch.fault;
        got.acc      = out_ch.acc_now;
        got.pc       = out_ch.pc_now;
        if (state_reports.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("result %0d arrived with no command outstanding", reports_seen);
        end else begin
          want = state_reports.pop_front();
          if (got.io_valid !== want.io_valid || got.io_value !== want.io_value ||
              got.halted !== want.halted || got.fault !== want.fault ||
              got.acc !== want.acc || got.pc !== want.pc) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display({"mismatch on result %0d: expected io %0b/%0d halted %0b fault %0d ",
                        "acc %0d pc %0d, got io %0b/%0d halted %0b fault %0d acc %0d pc %0d"},
                       reports_seen, want.io_valid, $signed(want.io_value), want.halted,
                       want.fault, $signed(want.acc), want.pc, got.io_valid,
                       $signed(got.io_value), got.halted, got.fault, $signed(got.acc), got.pc);
          end
        end
        reports_seen++;
      end
      // Hold-off wins, then calm, then random stalls.
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        stall_left = 0;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Long receiver hold-offs so the block backs up and stalls its input.
  initial begin
    hold_off = 1'b0;
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
    repeat (9000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [WORD_W-1:0] image [MEM_WORDS];
    int kind, n, base, r;

    rst_n        = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_WRITE;
    in_ch.mem_addr = '0;
    in_ch.mem_data = '0;
    in_ch.in_value = '0;
    out_ch.ready   = 1'b0;
    cmds_taken   = 0;
    reports_seen = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    send_gap     = 0;
    stall_left   = 0;
    n_exec = 0; n_read = 0; n_write = 0; n_restart = 0;
    n_out = 0; n_halt = 0; n_div0 = 0; n_pcflt = 0;
    mach_acc   = '0;
    mach_pc    = '0;
    mach_run   = 1'b1;
    mach_fault = FLT_NONE;

    // Load every word first so nothing ever reads unwritten memory.
    for (int i = 0; i < MEM_WORDS; i++) image[i] = (i < 80) ? rand_word() : $urandom();
    image[0]  = 32'd180;   // load most negative
    image[1]  = 32'd681;   // divide by minus one: wraps to most negative
    image[2]  = 32'd382;   // add most positive
    image[3]  = 32'd484;
    image[4]  = 32'd585;   // multiply by a negative
    image[5]  = 32'd786;   // input into word 86
    image[6]  = 32'd886;   // output it
    image[7]  = 32'd286;   // store acc
    image[8]  = 32'd886;
    image[9]  = 32'd1010;  // conditional branch, taken
    image[10] = -32'sd5;   // negative word: skip
    image[11] = 32'd1234;  // opcode past the last one: skip
    image[12] = 32'd180;
    image[13] = 32'd1016;  // conditional branch, not taken
    image[14] = 32'd920;   // unconditional branch
    image[20] = 32'd683;   // divide by zero
    image[80] = WORD_MIN;
    image[81] = '1;
    image[82] = WORD_MAX;
    image[83] = '0;
    image[84] = 32'd7;
    image[85] = -32'sd3;
    image[98] = 32'd899;
    image[99] = 32'd12345;
    for (int i = 0; i < MEM_WORDS; i++) add_cmd(CMD_WRITE, i, image[i], $urandom());

    // Directed walk through the program above.
    add_cmd(CMD_EXEC, 0, '0, WORD_MAX);
    for (int i = 1; i < 5; i++) add_cmd(CMD_EXEC, 0, '0, $urandom());
    add_cmd(CMD_EXEC, 0, '0, WORD_MIN);
    for (int i = 6; i < 16; i++) add_cmd(CMD_EXEC, 0, '0, $urandom());
    add_cmd(CMD_EXEC, 0, '0, $urandom());      // halted: no change
    add_cmd(CMD_READ, 99, $urandom(), $urandom());
    add_cmd(CMD_RESTART, 0, $urandom(), $urandom());
    add_cmd(CMD_WRITE, 0, 32'd998, $urandom());
    for (int i = 0; i < 4; i++) add_cmd(CMD_EXEC, 0, '0, $urandom());  // ends past word 99
    add_cmd(CMD_RESTART, 0, '0, '0);
    add_cmd(CMD_WRITE, 0, 32'd0, '0);            // halt at word 0
    add_cmd(CMD_EXEC, 0, '0, '0);

    // Random part: mostly short programs with restarts and runs of execution.
    while (command_backlog.size() < ITEM_COUNT) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          add_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, MEM_WORDS - 1),
                  $urandom(), rand_input());
      end else begin
        n    = $urandom_range(1, 10);
        base = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 20)
                                           : $urandom_range(0, MEM_WORDS - 1);
        for (int i = 0; i < n; i++)
          add_cmd(CMD_WRITE, (base + i) % MEM_WORDS, rand_word(), $urandom());
        if ($urandom_range(0, 4) != 0) add_cmd(CMD_RESTART, 0, $urandom(), $urandom());
        n = $urandom_range(5, 40);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 19);
          if (r == 0)
            add_cmd(CMD_READ, $urandom_range(0, MEM_WORDS - 1), $urandom(), $urandom());
          else if (r == 1)
            add_cmd(CMD_WRITE, $urandom_range(0, MEM_WORDS - 1), rand_word(), $urandom());
          else
            add_cmd(CMD_EXEC, $urandom_range(0, MEM_WORDS - 1), $urandom(), rand_input());
        end
      end
    end
    cmds_total = command_backlog.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every command taken, every report back, then a quiet tail.
    while (cmds_taken < cmds_total) @(posedge clk);
    while (state_reports.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d commands: %0d executes, %0d writes, %0d reads, %0d restarts",
             cmds_total, n_exec, n_write, n_read, n_restart);
    $display("machine emitted %0d outputs, halted %0d times, %0d divide and %0d pc faults",
             n_out, n_halt, n_div0, n_pcflt);
    if (err_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
